>>> rtl/bitmap_frame_allocator_defines.svh
// Assertion macros for the bitmap frame allocator.
// Used by the RTL files that carry concurrent checks; no dependencies.
`ifndef BITMAP_FRAME_ALLOCATOR_DEFINES_SVH
`define BITMAP_FRAME_ALLOCATOR_DEFINES_SVH

// Implication check, disabled during reset.
`define BFA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication check, disabled during reset.
`define BFA_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/bfa_pkg.sv
// Shared types and codes for the bitmap frame allocator.
// No dependencies.
package bfa_pkg;

  localparam int unsigned AddrW  = 24;
  localparam int unsigned LimitW = 25;
  localparam int unsigned CountW = 5;

  typedef enum logic [1:0] {
    OP_CLAIM   = 2'd0,
    OP_UNCLAIM = 2'd1,
    OP_ACQUIRE = 2'd2,
    OP_RELEASE = 2'd3
  } opcode_e;

  typedef struct packed {
    logic [1:0]        opcode;
    logic [AddrW-1:0]  address;
    logic [CountW-1:0] count;
    logic              last;
  } req_t;

  typedef struct packed {
    logic             status;
    logic [AddrW-1:0] grant_address;
    logic             final_res;
  } rsp_t;

endpackage

>>> rtl/bfa_req_if.sv
// Valid/ready channel interfaces for requests and responses.
// Depends on bfa_pkg.
interface bfa_req_if;
  logic           valid;
  logic           ready;
  bfa_pkg::req_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface bfa_rsp_if;
  logic           valid;
  logic           ready;
  bfa_pkg::rsp_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/bfa_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
module bfa_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 512
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule

>>> rtl/bfa_front.sv
// Front end: accepts requests and queues them for the engine.
// Depends on bfa_pkg and bfa_req_if.
module bfa_front #(
  parameter int unsigned Depth = 2
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  bfa_req_if.sink      req_i,
  output logic         q_valid_o,
  output bfa_pkg::req_t q_data_o,
  input  logic         q_pop_i
);
  import bfa_pkg::*;
  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;

  req_t            buf_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [PtrW:0]   cnt_q;
  logic            push;

  assign req_i.ready = (cnt_q != (PtrW+1)'(Depth));
  assign push        = req_i.valid && req_i.ready;
  assign q_valid_o   = (cnt_q != '0);
  assign q_data_o    = buf_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) begin
        wr_q <= (wr_q == PtrW'(Depth-1)) ? '0 : wr_q + 1'b1;
      end
      if (q_pop_i) begin
        rd_q <= (rd_q == PtrW'(Depth-1)) ? '0 : rd_q + 1'b1;
      end
      cnt_q <= cnt_q + (PtrW+1)'(push) - (PtrW+1)'(q_pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      buf_q[wr_q] <= req_i.data;
    end
  end
endmodule

>>> rtl/bfa_engine.sv
// Back end: executes queued requests against the occupancy map RAM.
// Depends on bfa_pkg, bfa_rsp_if, bfa_ram and the assertion macros.
`include "bitmap_frame_allocator_defines.svh"
module bfa_engine #(
  parameter int unsigned GrainBytes  = 4096,
  parameter int unsigned GrainCount  = 4096,
  parameter int unsigned WordBits    = 8,
  parameter int unsigned MaxRequest  = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [bfa_pkg::LimitW-1:0] limit_i,
  input  logic                  q_valid_i,
  input  bfa_pkg::req_t         q_data_i,
  output logic                  q_pop_o,
  bfa_rsp_if.source             rsp_o
);
  import bfa_pkg::*;

  localparam int unsigned Words = (GrainCount + WordBits - 1) / WordBits;
  localparam int unsigned WAW   = (Words > 1) ? $clog2(Words) : 1;
  localparam int unsigned BW    = (WordBits > 1) ? $clog2(WordBits) : 1;
  localparam int unsigned GBW   = (GrainBytes > 1) ? $clog2(GrainBytes) : 0;
  // wide enough for the map size and for any grain an address can name
  localparam int unsigned GMW   = $clog2(GrainCount) + 1;
  localparam int unsigned GAW   = AddrW - GBW + 1;
  localparam int unsigned GW    = (GMW > GAW) ? GMW : GAW;
  localparam int unsigned LW    = $clog2(MaxRequest);
  localparam int unsigned LIW   = (LW > 0) ? LW : 1;
  localparam int unsigned NW    = $clog2(MaxRequest + 1);
  localparam int unsigned SW    = 64;

  typedef enum logic [3:0] {
    S_IDLE, S_CLR, S_RD, S_WAIT, S_MOD, S_SCAN_RD, S_SCAN_WAIT, S_SCAN_BIT,
    S_RB_RD, S_RB_WAIT, S_EMIT, S_ONE
  } state_e;

  state_e           state_q;
  req_t             req_q;
  logic             rel_err_q;
  logic [WAW:0]     clr_q;
  logic [GW-1:0]    gr_q;
  logic [NW-1:0]    got_q, idx_q;
  logic [GW-1:0]    list_q [MaxRequest];
  logic             st_q;
  logic             rsp_valid_q;
  rsp_t             rsp_q;

  logic                ram_we;
  logic [WAW-1:0]      ram_addr;
  logic [WordBits-1:0] ram_wdata, ram_rdata;

  bfa_ram #(.Width(WordBits), .Depth(Words)) u_map (
    .clk_i, .we_i(ram_we), .addr_i(ram_addr), .wdata_i(ram_wdata), .rdata_o(ram_rdata)
  );

  // grain index from byte address, and grain byte address
  logic [GW-1:0] req_grain;
  assign req_grain = GW'({8'd0, req_q.address} >> GBW);

  function automatic logic [SW-1:0] g_addr(logic [GW-1:0] g);
    return SW'(g) << GBW;
  endfunction

  logic [BW-1:0] bit_sel;
  logic          cur_bit;
  logic          in_map;
  logic          out_free;
  logic [GW-1:0] rb_g;
  assign rb_g     = list_q[idx_q[LIW-1:0]];
  always_comb begin
    bit_sel = '0;
    unique case (state_q)
      S_SCAN_BIT: bit_sel = BW'(gr_q % WordBits);
      S_RB_WAIT:  bit_sel = BW'(rb_g % WordBits);
      default:    bit_sel = BW'(req_grain % WordBits);
    endcase
  end
  assign cur_bit  = ram_rdata[bit_sel];
  assign in_map   = (req_grain < GW'(GrainCount));
  assign out_free = rsp_o.ready || !rsp_valid_q;

  // scan continuation condition for grain gr_q
  logic scan_ok;
  assign scan_ok = (gr_q < GW'(GrainCount)) && (g_addr(gr_q) < SW'(limit_i));

  logic [WordBits-1:0] onehot;
  assign onehot = WordBits'(1) << bit_sel;

  always_comb begin
    ram_we    = 1'b0;
    ram_addr  = WAW'(req_grain / WordBits);
    ram_wdata = ram_rdata;
    unique case (state_q)
      S_CLR: begin
        ram_we    = 1'b1;
        ram_addr  = clr_q[WAW-1:0];
        ram_wdata = '0;
      end
      S_MOD: begin
        if (in_map) begin
          unique case (opcode_e'(req_q.opcode))
            OP_CLAIM: begin
              ram_we = 1'b1; ram_wdata = ram_rdata | onehot;
            end
            OP_ACQUIRE: ram_we = 1'b0;
            default: begin
              ram_we = (req_q.opcode == OP_UNCLAIM) ||
                       ({1'b0, req_q.address} < limit_i);
              ram_wdata = ram_rdata & ~onehot;
            end
          endcase
        end
      end
      S_SCAN_RD, S_SCAN_WAIT: ram_addr = WAW'(gr_q / WordBits);
      S_SCAN_BIT: begin
        ram_addr  = WAW'(gr_q / WordBits);
        ram_we    = scan_ok && !cur_bit;
        ram_wdata = ram_rdata | onehot;
      end
      S_RB_RD: ram_addr = WAW'(list_q[idx_q[LIW-1:0]] / WordBits);
      S_RB_WAIT: begin
        ram_addr  = WAW'(rb_g / WordBits);
        ram_we    = 1'b1;
        ram_wdata = ram_rdata & ~onehot;
      end
      default: ;
    endcase
  end

  assign q_pop_o = (state_q == S_IDLE) && q_valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      clr_q       <= '0;
      rel_err_q   <= 1'b0;
      rsp_valid_q <= 1'b0;
      gr_q        <= '0;
      got_q       <= '0;
      idx_q       <= '0;
      st_q        <= 1'b0;
    end else begin
      if (rsp_o.ready) rsp_valid_q <= 1'b0;
      unique case (state_q)
        S_CLR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == (WAW+1)'(Words-1)) state_q <= S_IDLE;
        end
        S_IDLE: if (q_valid_i) begin
          req_q <= q_data_i;
          if (q_data_i.opcode == OP_ACQUIRE) begin
            gr_q <= '0; got_q <= '0; idx_q <= '0;
            if (q_data_i.count == '0 || 32'(q_data_i.count) > 32'(MaxRequest)) begin
              st_q    <= (q_data_i.count != '0);
              state_q <= S_ONE;
            end else begin
              state_q <= S_SCAN_RD;
            end
          end else begin
            state_q <= S_RD;
          end
        end
        S_RD:   state_q <= S_WAIT;
        S_WAIT: state_q <= S_MOD;
        S_MOD: begin
          if (req_q.opcode == OP_RELEASE) begin
            logic e;
            e = rel_err_q || ({1'b0, req_q.address} >= limit_i) || !in_map || !cur_bit;
            if (req_q.last) begin
              st_q <= e; rel_err_q <= 1'b0; state_q <= S_ONE;
            end else begin
              rel_err_q <= e; state_q <= S_IDLE;
            end
          end else begin
            st_q <= !in_map || (cur_bit == (req_q.opcode == OP_CLAIM));
            state_q <= S_ONE;
          end
        end
        S_SCAN_RD:   state_q <= S_SCAN_WAIT;
        S_SCAN_WAIT: state_q <= S_SCAN_BIT;
        S_SCAN_BIT: begin
          if (!scan_ok) begin
            idx_q <= '0;
            state_q <= (got_q == '0) ? S_ONE : S_RB_RD;
            st_q <= 1'b1;
          end else begin
            if (!cur_bit) begin
              list_q[got_q[LIW-1:0]] <= gr_q;
            end
            gr_q <= gr_q + 1'b1;
            if (!cur_bit && (got_q + 1'b1) == NW'(req_q.count)) begin
              got_q <= got_q + 1'b1; idx_q <= '0; state_q <= S_EMIT;
            end else begin
              got_q <= got_q + NW'(!cur_bit);
              // a written word must be read back before the next bit
              state_q <= S_SCAN_RD;
            end
          end
        end
        S_RB_RD:   state_q <= S_RB_WAIT;
        S_RB_WAIT: begin
          idx_q <= idx_q + 1'b1;
          state_q <= ((idx_q + 1'b1) == got_q) ? S_ONE : S_RB_RD;
        end
        S_EMIT: if (out_free) begin
          rsp_valid_q <= 1'b1;
          rsp_q.status <= 1'b0;
          rsp_q.grant_address <= AddrW'(g_addr(list_q[idx_q[LIW-1:0]]));
          rsp_q.final_res <= ((idx_q + 1'b1) == got_q);
          idx_q <= idx_q + 1'b1;
          if ((idx_q + 1'b1) == got_q) state_q <= S_IDLE;
        end
        S_ONE: if (out_free) begin
          rsp_valid_q <= 1'b1;
          rsp_q.status <= st_q;
          rsp_q.grant_address <= '0;
          rsp_q.final_res <= 1'b1;
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign rsp_o.valid = rsp_valid_q;
  assign rsp_o.data  = rsp_q;

  `BFA_ASSERT_NXT(a_hold, clk_i, rst_ni, rsp_valid_q && !rsp_o.ready, rsp_valid_q,
                  "response dropped while stalled")
  `BFA_ASSERT_IMP(a_pop_idle, clk_i, rst_ni, q_pop_o, state_q == S_IDLE,
                  "request popped while busy")
  `BFA_ASSERT_IMP(a_got, clk_i, rst_ni, state_q == S_EMIT, got_q == NW'(req_q.count),
                  "grant count mismatch")
endmodule

>>> rtl/bitmap_frame_allocator.sv
// Bitmap frame allocator: one occupancy bit per grain, held in a map RAM of
// MAP_WORD_BITS-wide words. After reset a clearing pass writes every map word
// (512 by default), one per cycle, and no request is executed meanwhile.
// Claim, unclaim and release step through read, RAM wait and modify; all but
// a non-last release element then respond. Acquire scans grain by grain
// through the single map port (read, RAM wait, test and set), up to the limit
// or the map end, rolls back every grain it took on a shortage, and otherwise
// emits one beat per granted grain. A two-entry request queue decouples the
// input from the engine; results leave through a one-beat output register.
// Depends on bfa_pkg, the channel interfaces, bfa_front and bfa_engine.
module bitmap_frame_allocator #(
  parameter int unsigned GRAIN_BYTES   = 4096,
  parameter int unsigned GRAIN_COUNT   = 4096,
  parameter int unsigned MAP_WORD_BITS = 8,
  parameter int unsigned MAX_REQUEST   = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [bfa_pkg::LimitW-1:0] cfg_wdata_i,
  bfa_req_if.sink                    req_i,
  bfa_rsp_if.source                  rsp_o
);
  import bfa_pkg::*;

  // address limit register, reset to the full 16 MiB space
  logic [LimitW-1:0] limit_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LimitW'(25'h100_0000);
    end else if (cfg_we_i) begin
      limit_q <= cfg_wdata_i;
    end
  end

  logic q_valid, q_pop;
  req_t q_data;

  bfa_front #(.Depth(2)) u_front (
    .clk_i, .rst_ni, .req_i, .q_valid_o(q_valid), .q_data_o(q_data), .q_pop_i(q_pop)
  );

  bfa_engine #(
    .GrainBytes(GRAIN_BYTES), .GrainCount(GRAIN_COUNT),
    .WordBits(MAP_WORD_BITS), .MaxRequest(MAX_REQUEST)
  ) u_engine (
    .clk_i, .rst_ni, .limit_i(limit_q), .q_valid_i(q_valid), .q_data_i(q_data),
    .q_pop_o(q_pop), .rsp_o
  );
endmodule

>>> tb/sv/tb_bitmap_frame_allocator.sv
// Self-checking testbench for bitmap_frame_allocator: directed table, then random traffic.
// Depends on bfa_pkg, the bfa_req_if/bfa_rsp_if interfaces and the allocator RTL.
module tb_bitmap_frame_allocator;
  timeunit 1ns;
  timeprecision 1ps;
  import bfa_pkg::*;

  localparam int unsigned GRAIN_BYTES = 4096;
  localparam int unsigned GRAIN_COUNT = 4096;
  localparam int unsigned MAX_REQUEST = 16;
  localparam int unsigned LIMIT_MAX   = 25'd16777216;
  // Cycles without any accepted beat before the run is declared hung.
  localparam int unsigned STALL_LIMIT = 200000;
  localparam int unsigned DRAIN_CYCLES = 80;
  localparam int unsigned RAND_ITEMS = 310;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              cfg_we = 1'b0;
  logic [LimitW-1:0] cfg_wdata = '0;

  bfa_req_if req_if ();
  bfa_rsp_if rsp_if ();

  bitmap_frame_allocator i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .req_i       (req_if),
    .rsp_o       (rsp_if)
  );

  always #5 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Shadow of the allocator state
  // ---------------------------------------------------------------------------
  bit                used_map[GRAIN_COUNT];
  bit                rel_err_acc;
  logic [LimitW-1:0] addr_limit;
  rsp_t              grant_q[$];     // expected result beats, oldest first
  int unsigned       mismatches;
  int unsigned       send_idle_pct;
  int unsigned       recv_idle_pct;

  function automatic rsp_t mk_rsp(logic st, logic [AddrW-1:0] ga, logic fin);
    rsp_t r;
    r.status = st;
    r.grant_address = ga;
    r.final_res = fin;
    return r;
  endfunction

  // Updates the shadow map for one accepted request beat. When keep is
  // clear the result beats are computed but not queued (typed rows).
  function automatic void alloc_step(req_t r, bit keep);
    int unsigned grain;
    int unsigned got;
    int unsigned taken[MAX_REQUEST];
    rsp_t        out[$];
    grain = r.address / GRAIN_BYTES;
    case (opcode_e'(r.opcode))
      OP_CLAIM: begin
        if (used_map[grain]) out.push_back(mk_rsp(1'b1, '0, 1'b1));
        else begin
          used_map[grain] = 1'b1;
          out.push_back(mk_rsp(1'b0, '0, 1'b1));
        end
      end
      OP_UNCLAIM: begin
        if (!used_map[grain]) out.push_back(mk_rsp(1'b1, '0, 1'b1));
        else begin
          used_map[grain] = 1'b0;
          out.push_back(mk_rsp(1'b0, '0, 1'b1));
        end
      end
      OP_ACQUIRE: begin
        if (r.count == 0) out.push_back(mk_rsp(1'b0, '0, 1'b1));
        else if (r.count > MAX_REQUEST) out.push_back(mk_rsp(1'b1, '0, 1'b1));
        else begin
          got = 0;
          // Lowest free grains whose base address sits below the limit.
          for (int unsigned g = 0; g < GRAIN_COUNT && got < r.count; g++) begin
            if (64'(g) * GRAIN_BYTES >= 64'(addr_limit)) break;
            if (!used_map[g]) begin
              used_map[g] = 1'b1;
              taken[got] = g;
              got++;
            end
          end
          if (got < r.count) begin
            // Shortage: roll back everything this acquire took.
            for (int unsigned i = 0; i < got; i++) used_map[taken[i]] = 1'b0;
            out.push_back(mk_rsp(1'b1, '0, 1'b1));
          end else begin
            for (int unsigned i = 0; i < got; i++)
              out.push_back(mk_rsp(1'b0, AddrW'(taken[i] * GRAIN_BYTES), i + 1 == got));
          end
        end
      end
      default: begin
        // Release element: bit is cleared only for in-limit addresses.
        if (25'(r.address) >= addr_limit || !used_map[grain]) rel_err_acc = 1'b1;
        else used_map[grain] = 1'b0;
        if (r.last) begin
          out.push_back(mk_rsp(rel_err_acc, '0, 1'b1));
          rel_err_acc = 1'b0;
        end
      end
    endcase
    if (keep) foreach (out[i]) grant_q.push_back(out[i]);
  endfunction

  function automatic req_t mk_req(opcode_e op, logic [AddrW-1:0] a, int unsigned cnt, bit lst);
    req_t r;
    r.opcode = op;
    r.address = a;
    r.count = CountW'(cnt);
    r.last = lst;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Request side
  // ---------------------------------------------------------------------------
  // Drives one beat and returns at the edge where it is accepted; valid is
  // left high so back-to-back beats need no second assignment.
  task automatic drive_beat(req_t r);
    if ($urandom_range(99) < send_idle_pct) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    req_if.valid <= 1'b1;
    req_if.data <= r;
    do @(posedge clk_i); while (!req_if.ready);
  endtask

  task automatic send_checked(req_t r);
    drive_beat(r);
    alloc_step(r, 1'b1);
  endtask

  // Drain: wait until every expected beat is back, then let in-flight
  // result-less release elements finish before touching the register.
  task automatic drain();
    req_if.valid <= 1'b0;
    while (grant_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_limit(logic [LimitW-1:0] v);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    addr_limit = v;
  endtask

  // Mostly low grains, so acquire scans stay short; now and then any address.
  function automatic logic [AddrW-1:0] pick_addr();
    if ($urandom_range(99) < 8) return AddrW'($urandom());
    return AddrW'(($urandom_range(63) * GRAIN_BYTES) | $urandom_range(GRAIN_BYTES - 1));
  endfunction

  // A grain currently held, if one is found quickly among the low grains.
  function automatic logic [AddrW-1:0] pick_held();
    int unsigned g;
    for (int i = 0; i < 16; i++) begin
      g = $urandom_range(63);
      if (used_map[g]) return AddrW'(g * GRAIN_BYTES + $urandom_range(GRAIN_BYTES - 1));
    end
    return pick_addr();
  endfunction

  function automatic int unsigned pick_count();
    int unsigned p;
    p = $urandom_range(99);
    if (p < 6) return 0;
    if (p < 12) return MAX_REQUEST;
    if (p < 18) return $urandom_range(MAX_REQUEST + 1, 31);
    return $urandom_range(1, 4);
  endfunction

  // One random item or one release run; returns the number of release elements in a run, else 1.
  task automatic random_item(output int unsigned beats);
    int unsigned p;
    int unsigned run_len;
    p = $urandom_range(99);
    beats = 1;
    if (p < 20) send_checked(mk_req(OP_CLAIM, pick_addr(), $urandom_range(31), $urandom_range(1)));
    else if (p < 35)
      send_checked(mk_req(OP_UNCLAIM, pick_held(), $urandom_range(31), $urandom_range(1)));
    else if (p < 60)
      send_checked(mk_req(OP_ACQUIRE, AddrW'($urandom()), pick_count(), $urandom_range(1)));
    else begin
      // Release run: mostly held grains, sometimes junk or an interleaved op.
      run_len = $urandom_range(1, 4);
      beats = run_len;
      for (int unsigned i = 0; i < run_len; i++) begin
        if ($urandom_range(99) < 10)
          send_checked(mk_req(OP_CLAIM, pick_addr(), $urandom_range(31), $urandom_range(1)));
        send_checked(mk_req(OP_RELEASE,
                            ($urandom_range(99) < 80) ? pick_held() : pick_addr(),
                            $urandom_range(31), i + 1 == run_len));
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Response side: random backpressure and in-order checking
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin
    rsp_t want;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (grant_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result beat: status=%0d addr=%h final=%0d",
                   rsp_if.data.status, rsp_if.data.grant_address, rsp_if.data.final_res);
      end else begin
        want = grant_q.pop_front();
        if (rsp_if.data !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result mismatch: exp status=%0d addr=%h final=%0d, got %0d %h %0d",
                     want.status, want.grant_address, want.final_res,
                     rsp_if.data.status, rsp_if.data.grant_address, rsp_if.data.final_res);
        end
      end
    end
  end

  // Watchdog: cycles in a row with no beat accepted on either side.
  int unsigned quiet_cycles;
  always @(posedge clk_i) begin
    if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Directed table
  // ---------------------------------------------------------------------------
  typedef struct {
    req_t req;
    bit   typed;   // expectation given below instead of from the shadow model
    rsp_t want;
  } dir_row_t;

  dir_row_t dir_tab[$];

  function automatic void add_row(opcode_e op, logic [AddrW-1:0] a, int unsigned cnt, bit lst,
                                  bit typed, logic st);
    dir_row_t row;
    row.req = mk_req(op, a, cnt, lst);
    row.typed = typed;
    row.want = mk_rsp(st, '0, 1'b1);
    dir_tab.push_back(row);
  endfunction

  initial begin
    int unsigned sent;
    int unsigned beats;
    logic [LimitW-1:0] phase_limit[6];

    req_if.valid = 1'b0;
    req_if.data = '0;
    rsp_if.ready = 1'b0;
    quiet_cycles = 0;
    mismatches = 0;
    send_idle_pct = 18;
    recv_idle_pct = 66;
    for (int i = 0; i < GRAIN_COUNT; i++) used_map[i] = 1'b0;
    rel_err_acc = 1'b0;
    addr_limit = LIMIT_MAX;

    // Reset-limit rows: map extremes, double claim/free, acquire edge counts.
    add_row(OP_CLAIM,   24'h000000, 0,  0, 1, 1'b0);
    add_row(OP_CLAIM,   24'h000FFF, 31, 1, 1, 1'b1);   // same grain, already held
    add_row(OP_UNCLAIM, 24'h000000, 0,  0, 1, 1'b0);
    add_row(OP_UNCLAIM, 24'h000000, 0,  0, 1, 1'b1);   // already free
    add_row(OP_CLAIM,   24'hFFFFFF, 0,  0, 1, 1'b0);   // top grain
    add_row(OP_UNCLAIM, 24'hFFF000, 0,  1, 1, 1'b0);
    add_row(OP_ACQUIRE, 24'hFFFFFF, 0,  0, 1, 1'b0);   // zero count
    add_row(OP_ACQUIRE, 24'h000000, 17, 0, 1, 1'b1);   // over request limit
    add_row(OP_ACQUIRE, 24'h000000, 31, 1, 1, 1'b1);
    add_row(OP_ACQUIRE, 24'h000000, 16, 0, 0, 1'b0);   // largest grant
    add_row(OP_ACQUIRE, 24'h123456, 1,  0, 0, 1'b0);
    add_row(OP_RELEASE, 24'h000000, 0,  0, 0, 1'b0);
    add_row(OP_RELEASE, 24'h000123, 0,  1, 1, 1'b1);   // double release in run
    add_row(OP_RELEASE, 24'h001000, 31, 1, 0, 1'b0);
    add_row(OP_RELEASE, 24'h002000, 0,  0, 0, 1'b0);
    add_row(OP_CLAIM,   24'h400000, 0,  0, 0, 1'b0);   // interleaved inside run
    add_row(OP_RELEASE, 24'h003000, 0,  1, 0, 1'b0);
    add_row(OP_RELEASE, 24'hFFFFFF, 0,  1, 1, 1'b1);   // not held
    add_row(OP_CLAIM,   24'hABC123, 31, 1, 0, 1'b0);

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tab[i]) begin
      drive_beat(dir_tab[i].req);
      alloc_step(dir_tab[i].req, !dir_tab[i].typed);
      if (dir_tab[i].typed) grant_q.push_back(dir_tab[i].want);
    end
    drain();

    // Small limit: shortage with rollback, and release at the limit.
    write_limit(25'h0008000);
    send_checked(mk_req(OP_ACQUIRE, '0, 16, 0));
    send_checked(mk_req(OP_ACQUIRE, '0, 3, 0));
    send_checked(mk_req(OP_RELEASE, 24'h008000, 0, 1));
    drain();
    // Zero limit: nothing can be acquired, every release is out of range.
    write_limit('0);
    send_checked(mk_req(OP_ACQUIRE, '0, 1, 0));
    send_checked(mk_req(OP_RELEASE, 24'h000000, 0, 1));
    drain();

    phase_limit[0] = LIMIT_MAX;
    phase_limit[1] = 25'h0010000;
    phase_limit[2] = LimitW'($urandom_range(1, 40) * GRAIN_BYTES + $urandom_range(4095));
    phase_limit[3] = LimitW'($urandom_range(1 << 16, LIMIT_MAX));
    phase_limit[4] = '0;
    phase_limit[5] = LIMIT_MAX;

    sent = 0;
    for (int ph = 0; ph < 6; ph++) begin
      write_limit(phase_limit[ph]);
      while (sent < (ph + 1) * RAND_ITEMS / 6) begin
        // Thirds of the run: sender light/receiver heavy, then swapped, then none.
        if (sent < RAND_ITEMS / 3) begin
          send_idle_pct = 18;
          recv_idle_pct = 66;
        end else if (sent < 2 * RAND_ITEMS / 3) begin
          send_idle_pct = 66;
          recv_idle_pct = 18;
        end else begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
        random_item(beats);
        sent += beats;
      end
      drain();
    end

    if (mismatches == 0 && grant_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
